### hdl/bct_pkg.sv
// shared types and constants of the bezier curve tessellator
package bct_pkg;

  // item kinds on the input tuser
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_CUBIC = 2'd1;
  localparam logic [1:0] FUNC_QUAD  = 2'd2;

  // restoring divider runs one quotient bit per cycle over i << 16
  localparam int DIV_STEPS = 23;
  // weight products, one idle slot, twelve coordinate products, final writeback
  localparam int PIPE_LEN  = 21;
  localparam int PIPE_CW0  = 8;

  // input and output tdata widths
  localparam int IN_W   = 144;
  localparam int OUT_W  = 224;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_DIV_STEP,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_UU,
    MUL_UT,
    MUL_TT,
    MUL_UUU,
    MUL_UUT,
    MUL_UTT,
    MUL_TTT,
    MUL_CW
  } mul_op_t;

  typedef struct packed {
    dp_op_t     op;
    mul_op_t    mul;
    logic [1:0] pt;
    logic [1:0] axis;
  } bct_cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_free;
  } bct_stat_t;

endpackage

### hdl/bct_ctrl.sv
// sequencer of the tessellator: divide, weight and coordinate schedule, emit
module bct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic [1:0]        func,
  output logic              s_tready,
  input  bct_pkg::bct_stat_t stat,
  output bct_pkg::bct_cmd_t  cmd
);
  import bct_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_PIPE, S_EMIT} state_t;

  state_t     state;
  logic [4:0] cnt;
  logic [3:0] cw;

  assign s_tready = (state == S_IDLE);
  assign cw       = 4'(cnt - 5'(PIPE_CW0));

  // command decode
  always_comb begin
    cmd = '{op: OP_NONE, mul: MUL_NONE, pt: 2'd0, axis: 2'd0};
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (func == FUNC_LOAD) cmd.op = OP_LOAD;
          else if (func == FUNC_CUBIC || func == FUNC_QUAD) cmd.op = OP_START;
        end
      end
      S_DIV: cmd.op = OP_DIV_STEP;
      S_PIPE: begin
        case (cnt)
          5'd0: cmd.mul = MUL_UU;
          5'd1: cmd.mul = MUL_UT;
          5'd2: cmd.mul = MUL_TT;
          5'd3: cmd.mul = MUL_UUU;
          5'd4: cmd.mul = MUL_UUT;
          5'd5: cmd.mul = MUL_UTT;
          5'd6: cmd.mul = MUL_TTT;
          default: begin
            if (cnt >= 5'(PIPE_CW0) && cnt < 5'(PIPE_CW0 + 12)) begin
              cmd.mul  = MUL_CW;
              cmd.pt   = cw[1:0];
              cmd.axis = cw[3:2];
            end
          end
        endcase
      end
      S_EMIT: if (stat.out_free) cmd.op = OP_EMIT;
      default: cmd.op = OP_NONE;
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.op == OP_START) begin
            state <= S_DIV;
            cnt   <= '0;
          end
        end
        S_DIV: begin
          if (cnt == 5'(DIV_STEPS - 1)) begin
            state <= S_PIPE;
            cnt   <= '0;
          end else cnt <= cnt + 5'd1;
        end
        S_PIPE: begin
          if (cnt == 5'(PIPE_LEN - 1)) begin
            state <= S_EMIT;
            cnt   <= '0;
          end else cnt <= cnt + 5'd1;
        end
        S_EMIT: begin
          if (stat.out_free) begin
            state <= stat.last_step ? S_IDLE : S_DIV;
            cnt   <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/bct_dpath.sv
// datapath: control point store, divider, shared multiplier, accumulator, output register
module bct_dpath #(
  parameter int SEG_LIMIT = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 func,
  input  logic [bct_pkg::IN_W-1:0]   in_data,
  input  bct_pkg::bct_cmd_t          cmd,
  output bct_pkg::bct_stat_t         stat,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [bct_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tlast
);
  import bct_pkg::*;

  logic [31:0] store [4][3];
  logic [31:0] prev  [3];
  logic [31:0] cur   [3];
  logic [6:0]  n, step_index, seg_in, n_clamp;
  logic        cubic;
  logic [31:0] color;
  logic [22:0] dq;
  logic [7:0]  rem, r2;
  logic        qbit;
  logic [16:0] t, u;
  logic [33:0] uu, ut, tt;
  logic [16:0] w [4];
  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [52:0] prod;
  mul_op_t     prod_op;
  logic [1:0]  prod_pt, prod_axis;
  logic [54:0] p3;
  logic signed [52:0] acc, sum;
  logic signed [36:0] shr;
  logic [31:0] sat;

  assign seg_in  = in_data[104:98];
  assign n_clamp = (seg_in == 7'd0) ? 7'd1 :
                   (seg_in > 7'(SEG_LIMIT)) ? 7'(SEG_LIMIT) : seg_in;
  assign t = dq[16:0];
  assign u = 17'h10000 - t;

  assign stat.last_step = (step_index == n);
  assign stat.out_free  = !m_tvalid || m_tready;

  // restoring divider step
  assign r2   = {rem[6:0], dq[22]};
  assign qbit = (r2 >= {1'b0, n});

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      MUL_UU:  begin mul_a = 35'(u);  mul_b = 18'(u); end
      MUL_UT:  begin mul_a = 35'(u);  mul_b = 18'(t); end
      MUL_TT:  begin mul_a = 35'(t);  mul_b = 18'(t); end
      MUL_UUU: begin mul_a = 35'(uu); mul_b = 18'(u); end
      MUL_UUT: begin mul_a = 35'(uu); mul_b = 18'(t); end
      MUL_UTT: begin mul_a = 35'(ut); mul_b = 18'(t); end
      MUL_TTT: begin mul_a = 35'(tt); mul_b = 18'(t); end
      MUL_CW: begin
        mul_a = 35'(signed'(store[cmd.pt][cmd.axis]));
        mul_b = 18'(w[cmd.pt]);
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // writeback helpers
  assign p3  = {2'b00, prod} + {1'b0, prod, 1'b0};
  assign sum = ((prod_pt == 2'd0) ? 53'sd0 : acc) + prod;
  assign shr = sum[52:16];
  always_comb begin
    if (shr > 37'sh7FFFFFFF) sat = 32'h7FFFFFFF;
    else if (shr < -37'sh80000000) sat = 32'h80000000;
    else sat = shr[31:0];
  end

  // multiplier register
  always_ff @(posedge clk) begin
    if (rst) prod_op <= MUL_NONE;
    else     prod_op <= cmd.mul;
    prod      <= mul_a * mul_b;
    prod_pt   <= cmd.pt;
    prod_axis <= cmd.axis;
  end

  // product writeback
  always_ff @(posedge clk) begin
    case (prod_op)
      MUL_UU:  uu <= prod[33:0];
      MUL_UT:  ut <= prod[33:0];
      MUL_TT:  tt <= prod[33:0];
      MUL_UUU: w[0] <= cubic ? prod[48:32] : uu[32:16];
      MUL_UUT: w[1] <= cubic ? p3[48:32]   : ut[31:15];
      MUL_UTT: w[2] <= cubic ? p3[48:32]   : tt[32:16];
      MUL_TTT: w[3] <= cubic ? prod[48:32] : 17'd0;
      MUL_CW: begin
        acc <= sum;
        if (prod_pt == 2'd3) cur[prod_axis] <= sat;
      end
      default: acc <= acc;
    endcase
  end

  // control point store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < 4; p++)
        for (int k = 0; k < 3; k++) store[p][k] <= '0;
    end else if (cmd.op == OP_LOAD) begin
      store[in_data[1:0]][0] <= in_data[33:2];
      store[in_data[1:0]][1] <= in_data[65:34];
      store[in_data[1:0]][2] <= in_data[97:66];
    end
  end

  // curve setup, divider and step tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      step_index <= '0;
      n          <= 7'd1;
    end else begin
      case (cmd.op)
        OP_START: begin
          n          <= n_clamp;
          cubic      <= (func == FUNC_CUBIC);
          color      <= in_data[136:105];
          for (int k = 0; k < 3; k++) prev[k] <= store[0][k];
          step_index <= 7'd1;
          dq         <= {7'd1, 16'd0};
          rem        <= '0;
        end
        OP_DIV_STEP: begin
          rem <= qbit ? (r2 - {1'b0, n}) : r2;
          dq  <= {dq[21:0], qbit};
        end
        OP_EMIT: begin
          for (int k = 0; k < 3; k++) prev[k] <= cur[k];
          if (!stat.last_step) begin
            step_index <= step_index + 7'd1;
            dq         <= {step_index + 7'd1, 16'd0};
            rem        <= '0;
          end
        end
        default: rem <= rem;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.op == OP_EMIT) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (cmd.op == OP_EMIT) begin
      m_tdata <= {color, cur[2], cur[1], cur[0], prev[2], prev[1], prev[0]};
      m_tlast <= stat.last_step;
    end
  end

endmodule

### hdl/bezier_curve_tessellator_unit.sv
// top level of the bezier curve tessellator
//
// channel  dir  tdata                                              tuser  tlast
// s_*      in   point_index, coord_x/y/z, segment_count, color     func   -
// m_*      out  from_x/y/z, to_x/y/z, seg_color                    -      last
//
// a load item writes one control point; a start item gives n segments,
// each taking the divider steps, then the multiplier schedule, then an
// emit, paced by the one-bit-per-cycle divider and the single shared
// multiplier. a stalled output holds the next emit.
// reset clears the control store, the sequencer and the output valid.
module bezier_curve_tessellator_unit #(
  parameter int SEG_LIMIT = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_index[1:0], coord_x[33:2], coord_y[65:34], coord_z[97:66],
  // segment_count[104:98], color_rgba[136:105], zero pad
  input  logic [143:0] s_tdata,
  // func[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // from_x, from_y, from_z, to_x, to_y, to_z, seg_color (32 bits each, low first)
  output logic [223:0] m_tdata,
  output logic         m_tlast
);
  import bct_pkg::*;

  bct_cmd_t  cmd;
  bct_stat_t stat;

  bct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .func     (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bct_dpath #(.SEG_LIMIT(SEG_LIMIT)) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .func     (s_tuser),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### hdl/bct_check.sv
// port-level checks of the tessellator and their binding
module bct_check (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [223:0] m_tdata,
  input logic         m_tlast
);
  import bct_pkg::*;

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output item changed");

  // a start item closes the input until the curve is done
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == FUNC_CUBIC || s_tuser == FUNC_QUAD)
    |=> !s_tready)
    else $error("input open right after start item");

  // reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

endmodule

bind bezier_curve_tessellator_unit bct_check u_bct_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
